>>> hdl/agcs_pkg.sv
package agcs_pkg;

   localparam int MaxBodiesDefault = 16;
   localparam int IdxW = 4;

   // Q16.16 constants
   localparam logic signed [31:0] DropProbe = 32'sd655;
   localparam logic signed [31:0] GravStep = 32'sd1286;
   localparam logic signed [31:0] VelCap = -32'sd655360;

   // doubled-scale bounds are held at 36 bits
   localparam int BW = 36;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_PROBE = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SETUP1,
      ST_SCAN1,
      ST_DECIDE,
      ST_SETUP2,
      ST_SCAN2,
      ST_COMMIT,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic write_body;
      logic setup_probe;
      logic setup_drop;
      logic setup_move;
      logic scan_clear;
      logic scan_step;
      logic set_vel_zero;
      logic set_vel_new;
      logic commit_move;
      logic set_hit;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type func;
      logic idx_ok;
      logic self_valid;
      logic bottom_pos;
      logic scan_done;
      logic scan_hit;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

>>> hdl/agcs_ctrl.sv
module agcs_ctrl
   import agcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic hit1_ff, hit1_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_READ;
         ST_READ: begin
            if (!sts.idx_ok) state_in = ST_OUT;
            else if (sts.func == FUNC_LOAD) state_in = ST_OUT;
            else if (sts.func == FUNC_NONE || !sts.self_valid) state_in = ST_OUT;
            else state_in = ST_SETUP1;
         end
         ST_SETUP1: begin
            if (sts.func == FUNC_TICK && !sts.bottom_pos) state_in = ST_DECIDE;
            else state_in = ST_SCAN1;
         end
         ST_SCAN1: if (sts.scan_done) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (sts.func == FUNC_PROBE || !sts.bottom_pos || hit1_ff) state_in = ST_OUT;
            else state_in = ST_SETUP2;
         end
         ST_SETUP2: state_in = ST_SCAN2;
         ST_SCAN2: if (sts.scan_done) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hit1_in = hit1_ff;
      if (state_ff == ST_SETUP1) hit1_in = 1'b0;
      else if (state_ff == ST_SCAN1 && sts.scan_done) hit1_in = sts.scan_hit;
   end

   // outputs
   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load_item = in_valid;
         end
         ST_READ: begin
            cmd.write_body = sts.idx_ok && sts.func == FUNC_LOAD;
            cmd.out_load = 1'b1;
         end
         ST_SETUP1: begin
            cmd.scan_clear = 1'b1;
            cmd.setup_probe = sts.func == FUNC_PROBE;
            cmd.setup_drop = sts.func == FUNC_TICK;
         end
         ST_SCAN1: cmd.scan_step = !sts.scan_done;
         ST_DECIDE: begin
            if (sts.func == FUNC_PROBE) begin
               cmd.set_hit = hit1_ff;
            end else if (!sts.bottom_pos || hit1_ff) begin
               cmd.set_vel_zero = 1'b1;
               cmd.set_hit = hit1_ff;
            end else begin
               cmd.set_vel_new = 1'b1;
            end
         end
         ST_SETUP2: begin
            cmd.scan_clear = 1'b1;
            cmd.setup_move = 1'b1;
         end
         ST_SCAN2: cmd.scan_step = !sts.scan_done;
         ST_COMMIT: begin
            if (sts.scan_hit) cmd.set_hit = 1'b1;
            else cmd.commit_move = 1'b1;
         end
         ST_OUT: out_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hit1_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit1_ff <= hit1_in;
      end
   end

endmodule

>>> hdl/agcs_datapath.sv
module agcs_datapath
   import agcs_pkg::*;
#(
   parameter int MAX_BODIES = MaxBodiesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [IdxW-1:0]    in_index,
   input  logic [1:0]         in_func,
   input  logic [31:0]        in_vec_x,
   input  logic [31:0]        in_vec_y,
   input  logic [31:0]        in_vec_z,
   input  logic [31:0]        in_ctr_x,
   input  logic [31:0]        in_ctr_y,
   input  logic [31:0]        in_ctr_z,
   input  logic [30:0]        in_ext_x,
   input  logic [30:0]        in_ext_y,
   input  logic [30:0]        in_ext_z,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic               out_hit,
   output logic               out_moved,
   output logic [31:0]        out_pos_y,
   output logic [31:0]        out_vel_y
);

   localparam int SW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CW = $clog2(MAX_BODIES + 1);

   // body table
   logic signed [31:0] pos_ff [3][MAX_BODIES];
   logic signed [31:0] ctr_ff [3][MAX_BODIES];
   logic        [30:0] ext_ff [3][MAX_BODIES];
   logic signed [31:0] vel_ff [MAX_BODIES];
   logic [MAX_BODIES-1:0] valid_ff;

   // latched item
   func_type func_ff;
   logic [IdxW-1:0] idx_ff;
   logic signed [31:0] vec_ff [3];
   logic signed [31:0] ctrl_ff [3];
   logic [30:0] extl_ff [3];

   // test box, doubled scale
   logic signed [BW-1:0] lo_ff [3], hi_ff [3], lo_in [3], hi_in [3];
   logic [CW-1:0] cnt_ff;
   logic shit_ff;
   logic hit_ff, moved_ff;
   logic signed [31:0] py_ff, vy_ff;

   logic idx_ok;
   logic [SW-1:0] me;
   logic [SW-1:0] k;
   logic signed [31:0] off [3];
   logic signed [31:0] me_pos [3];
   logic signed [BW-1:0] bot2;
   logic signed [BW-1:0] lim2;
   logic signed [33:0] lim, dec, vnew, np;
   logic signed [31:0] vsat;
   logic cand;
   logic ov [3];

   assign idx_ok = 32'(idx_ff) < 32'(MAX_BODIES);
   assign me = SW'(idx_ff);
   assign k = cnt_ff[SW-1:0];

   always_comb begin
      for (int a = 0; a < 3; a++) me_pos[a] = pos_ff[a][me];
   end

   assign bot2 = BW'(2 * (BW'(me_pos[1]) + BW'(ctr_ff[1][me]))) - BW'({1'b0, ext_ff[1][me]});

   // new velocity
   always_comb begin
      lim2 = BW'(2 * BW'(ctr_ff[1][me])) - BW'({1'b0, ext_ff[1][me]});
      lim = 34'(lim2 >>> 1);
      if (lim > 34'(VelCap)) lim = 34'(VelCap);
      dec = 34'(vel_ff[me]) - 34'(GravStep);
      vnew = (dec > lim) ? dec : lim;
      vsat = sat32(vnew);
      np = 34'(me_pos[1]) + 34'(vel_ff[me]);
   end

   // offset for the test box
   always_comb begin
      for (int a = 0; a < 3; a++) off[a] = '0;
      if (cmd.setup_probe) begin
         for (int a = 0; a < 3; a++) off[a] = vec_ff[a];
      end else if (cmd.setup_drop) begin
         off[1] = -DropProbe;
      end else if (cmd.setup_move) begin
         off[1] = vel_ff[me];
      end
      for (int a = 0; a < 3; a++) begin
         lo_in[a] = BW'(2 * (BW'(me_pos[a]) + BW'(off[a]) + BW'(ctr_ff[a][me])))
                    - BW'({1'b0, ext_ff[a][me]});
         hi_in[a] = BW'(2 * (BW'(me_pos[a]) + BW'(off[a]) + BW'(ctr_ff[a][me])))
                    + BW'({1'b0, ext_ff[a][me]});
      end
   end

   // one candidate body per cycle, signed bounds
   always_comb begin
      logic signed [BW-1:0] c2;
      for (int a = 0; a < 3; a++) begin
         c2 = BW'(2 * (BW'(pos_ff[a][k]) + BW'(ctr_ff[a][k])));
         ov[a] = (hi_ff[a] > c2 - BW'($signed({1'b0, ext_ff[a][k]})))
                 && (lo_ff[a] < c2 + BW'($signed({1'b0, ext_ff[a][k]})));
      end
      cand = valid_ff[k] && (k != me) && ov[0] && ov[1] && ov[2];
   end

   always_comb begin
      sts.func = func_ff;
      sts.idx_ok = idx_ok;
      sts.self_valid = idx_ok && valid_ff[me];
      sts.bottom_pos = bot2 > 0;
      sts.scan_done = shit_ff || (cnt_ff == CW'(MAX_BODIES));
      sts.scan_hit = shit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < MAX_BODIES; i++) begin
            vel_ff[i] <= '0;
            for (int a = 0; a < 3; a++) pos_ff[a][i] <= '0;
         end
      end else begin
         if (cmd.write_body) begin
            valid_ff[me] <= 1'b1;
            vel_ff[me] <= '0;
            for (int a = 0; a < 3; a++) pos_ff[a][me] <= vec_ff[a];
         end
         if (cmd.set_vel_zero) vel_ff[me] <= '0;
         if (cmd.set_vel_new) vel_ff[me] <= vsat;
         if (cmd.commit_move) pos_ff[1][me] <= sat32(np);
      end
   end

   // center and size need no reset
   always_ff @(posedge clock) begin
      if (cmd.write_body) begin
         for (int a = 0; a < 3; a++) begin
            ctr_ff[a][me] <= ctrl_ff[a];
            ext_ff[a][me] <= extl_ff[a];
         end
      end
   end

   // item latch, scan and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff <= func_type'(in_func);
         idx_ff <= in_index;
         vec_ff[0] <= in_vec_x; vec_ff[1] <= in_vec_y; vec_ff[2] <= in_vec_z;
         ctrl_ff[0] <= in_ctr_x; ctrl_ff[1] <= in_ctr_y; ctrl_ff[2] <= in_ctr_z;
         extl_ff[0] <= in_ext_x; extl_ff[1] <= in_ext_y; extl_ff[2] <= in_ext_z;
      end
      if (cmd.scan_clear) begin
         cnt_ff <= '0;
         shit_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= lo_in[a];
            hi_ff[a] <= hi_in[a];
         end
      end else if (cmd.scan_step) begin
         cnt_ff <= cnt_ff + 1'b1;
         shit_ff <= cand;
      end
      if (cmd.out_load) begin
         hit_ff <= 1'b0;
         moved_ff <= 1'b0;
      end
      if (cmd.set_hit) hit_ff <= 1'b1;
      if (cmd.commit_move) moved_ff <= sat32(np) != me_pos[1];
   end

   // result fields follow the table
   always_comb begin
      py_ff = idx_ok ? me_pos[1] : '0;
      vy_ff = idx_ok ? vel_ff[me] : '0;
   end

   assign out_hit = hit_ff;
   assign out_moved = moved_ff;
   assign out_pos_y = py_ff;
   assign out_vel_y = vy_ff;

endmodule

>>> hdl/aabb_gravity_collision_step_top.sv
// channel  | ports                     | contents
// request  | req_tvalid/tready/tdata   | one command item per transfer
// response | rsp_tvalid/tready/tdata   | one result item per request
// the overlap test compares one stored body per cycle and a scan
// ends early on the first hit.
// reset is synchronous and clears positions, velocities and valid bits.
// the response holds until taken; no new request is taken meanwhile.
module aabb_gravity_collision_step_top
   import agcs_pkg::*;
#(
   parameter int MAX_BODIES = MaxBodiesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // func, body_index, vec_x, vec_y, vec_z, ctr_x, ctr_y, ctr_z, ext_x, ext_y, ext_z, pad
   input  logic [295:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit, moved, out_pos_y, out_vel_y, pad
   output logic [71:0]  rsp_tdata
);

   cmd_type cmd;
   sts_type sts;
   logic hit, moved;
   logic [31:0] py, vy;

   agcs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   agcs_datapath #(.MAX_BODIES(MAX_BODIES)) u_dp (
      .clock(clock), .reset(reset),
      .in_func(req_tdata[1:0]), .in_index(req_tdata[5:2]),
      .in_vec_x(req_tdata[37:6]), .in_vec_y(req_tdata[69:38]),
      .in_vec_z(req_tdata[101:70]),
      .in_ctr_x(req_tdata[133:102]), .in_ctr_y(req_tdata[165:134]),
      .in_ctr_z(req_tdata[197:166]),
      .in_ext_x(req_tdata[228:198]), .in_ext_y(req_tdata[259:229]),
      .in_ext_z(req_tdata[290:260]),
      .cmd(cmd), .sts(sts),
      .out_hit(hit), .out_moved(moved), .out_pos_y(py), .out_vel_y(vy)
   );

   assign rsp_tdata = {6'd0, vy, py, moved, hit};

   logic [4:0] unused_pad;
   assign unused_pad = req_tdata[295:291];

endmodule
